[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks of the speed regulator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A check that also holds across reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/rpdr_pkg.sv]
// ----------------------------------------------------------------------------
// rpdr_pkg
// Widths, register indexes, reset values and pipeline word types of the
// speed regulator.
// ----------------------------------------------------------------------------
package rpdr_pkg;

  // Field and arithmetic widths.
  localparam int SPEED_W    = 16;
  localparam int ERR_W      = SPEED_W + 1;
  localparam int DIFF_W     = ERR_W + 1;
  localparam int SUM_W      = 48;
  localparam int HALF_W     = SUM_W / 2;
  localparam int GAIN_W     = 32;
  localparam int FRAC_W     = 32;
  localparam int DUTY_W     = 8;
  localparam int DUTY_MAX   = 255;
  localparam int LIMIT_EXP  = 40;
  localparam int P_W        = GAIN_W + ERR_W + 1;
  localparam int D_W        = GAIN_W + DIFF_W + 1;
  localparam int ILO_W      = GAIN_W + HALF_W;
  localparam int IHI_W      = GAIN_W + (SUM_W - HALF_W) + 1;
  localparam int ACC_W      = GAIN_W + SUM_W + 3;
  localparam int FL_W       = ACC_W - FRAC_W;
  localparam int PID_W      = LIMIT_EXP + 2;
  localparam int NEXT_W     = PID_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_PROP   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INTEG  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_DERIV  = CFG_IDX_W'(3);

  // Register values after reset (gains are unsigned Q0.32).
  localparam logic [SPEED_W-1:0] TARGET_RST = SPEED_W'(200);
  localparam logic [GAIN_W-1:0]  PROP_RST   = GAIN_W'(214748365);
  localparam logic [GAIN_W-1:0]  INTEG_RST  = GAIN_W'(6442);
  localparam logic [GAIN_W-1:0]  DERIV_RST  = GAIN_W'(429);

  // Configuration seen by the pipeline.
  typedef struct packed {
    logic [SPEED_W-1:0] target;
    logic [GAIN_W-1:0]  prop;
    logic [GAIN_W-1:0]  integ;
    logic [GAIN_W-1:0]  deriv;
  } cfg_t;

  // Error terms of one sample.
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
  } err_item_t;

  // Partial products of one sample.
  typedef struct packed {
    logic signed [P_W-1:0]   p;
    logic signed [D_W-1:0]   d;
    logic        [ILO_W-1:0] ilo;
    logic signed [IHI_W-1:0] ihi;
  } prod_item_t;

  // Pairwise sums of the partial products.
  typedef struct packed {
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
  } pair_item_t;

endpackage

[rtl/core/rpm_pid_duty_regulator.sv]
// ----------------------------------------------------------------------------
// rpm_pid_duty_regulator
// PID speed loop: one measured speed word in, one PWM duty word out.
// ----------------------------------------------------------------------------
// Each word on the in_ stream is one speed sample in rpm. The block forms the
// error against target_speed, weighs error, earlier error sum and error
// change with three unsigned Q0.32 gains, adds the floored result to the held
// duty and clamps it to 0..255. Each sample yields exactly one out_ word:
// the new duty in tdata and, in tuser, a flag that is set when the clamp
// acted.
// Gains and set point are written on the cfg_ port while the stream is idle.
// From acceptance to out_tvalid the word passes the input register, the error
// stage, the product stage and two adder stages and then sits in the output
// register. One word is taken every cycle while in_tready is high; each
// loop from one sample to the next closes within a single stage: error sum
// and last error in the error stage, the held duty in the output stage.
// A stalled receiver holds the output word; the stages behind it keep
// filling, and in_tready falls only when all six are full.
// Reset clears the loop state (error sum, last error, held duty), loads the
// default gains and set point and empties the pipeline.
// ----------------------------------------------------------------------------
module rpm_pid_duty_regulator import rpdr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream: tdata[15:0] = measured_speed.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  // Result stream: tdata[7:0] = duty; tuser[0] = limited.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,
  output logic                  out_tuser,
  // Configuration writes.
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t              cfg_r;
  logic              err_valid;
  logic              err_ready;
  err_item_t         err_item;
  logic              prod_valid;
  logic              prod_ready;
  prod_item_t        prod_item;
  logic              pid_valid;
  logic              pid_ready;
  logic [PID_W-1:0]  pid;

  // Register bank.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target <= TARGET_RST;
      cfg_r.prop   <= PROP_RST;
      cfg_r.integ  <= INTEG_RST;
      cfg_r.deriv  <= DERIV_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET: cfg_r.target <= cfg_wdata[SPEED_W-1:0];
        REG_PROP:   cfg_r.prop   <= cfg_wdata[GAIN_W-1:0];
        REG_INTEG:  cfg_r.integ  <= cfg_wdata[GAIN_W-1:0];
        REG_DERIV:  cfg_r.deriv  <= cfg_wdata[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rpdr_error_stage u_error (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_meas   (in_tdata[SPEED_W-1:0]),
    .out_valid (err_valid),
    .out_ready (err_ready),
    .out_item  (err_item)
  );

  rpdr_product_stage u_product (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (err_valid),
    .in_ready  (err_ready),
    .in_item   (err_item),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .out_item  (prod_item)
  );

  rpdr_sum_stage u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .in_item   (prod_item),
    .out_valid (pid_valid),
    .out_ready (pid_ready),
    .out_pid   (pid)
  );

  rpdr_duty_stage u_duty (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pid_valid),
    .in_ready    (pid_ready),
    .in_pid      (pid),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_duty    (out_tdata),
    .out_limited (out_tuser)
  );

endmodule

[rtl/core/rpdr_error_stage.sv]
// ----------------------------------------------------------------------------
// rpdr_error_stage
// Input register, error, error difference and saturating integral update.
// ----------------------------------------------------------------------------
module rpdr_error_stage import rpdr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [SPEED_W-1:0] in_meas,
  output logic               out_valid,
  input  logic               out_ready,
  output err_item_t          out_item
);

  logic                     meas_v_r;
  logic [SPEED_W-1:0]       meas_r;
  logic                     item_v_r;
  err_item_t                item_r;
  err_item_t                item_nxt;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [ERR_W-1:0]  last_err_r;
  logic signed [ERR_W-1:0]  err;
  logic signed [SUM_W:0]    sum_ext;
  logic                     slot_rdy;
  logic                     advance;

  // Each slot moves on when it is empty or its successor takes the word.
  assign slot_rdy  = !item_v_r || out_ready;
  assign in_ready  = !meas_v_r || slot_rdy;
  assign advance   = meas_v_r && slot_rdy;
  assign out_valid = item_v_r;
  assign out_item  = item_r;

  // Error and difference against the previous error.
  always_comb begin
    err = $signed({1'b0, cfg.target}) - $signed({1'b0, meas_r});
    item_nxt.err  = err;
    item_nxt.diff = DIFF_W'(err) - DIFF_W'(last_err_r);
    item_nxt.sum  = sum_r;
  end

  // The integral takes the current error after it has been used, and sticks
  // at the signed limits when the addition overflows.
  always_comb begin
    sum_ext = $signed({sum_r[SUM_W-1], sum_r}) + (SUM_W + 1)'(err);
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_nxt = {sum_ext[SUM_W], {(SUM_W - 1){!sum_ext[SUM_W]}}};
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
  end

  // Control and loop state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meas_v_r   <= 1'b0;
      item_v_r   <= 1'b0;
      sum_r      <= '0;
      last_err_r <= '0;
    end else begin
      if (in_ready) begin
        meas_v_r <= in_valid;
      end
      if (slot_rdy) begin
        item_v_r <= meas_v_r;
      end
      if (advance) begin
        sum_r      <= sum_nxt;
        last_err_r <= err;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      meas_r <= in_meas;
    end
    if (advance) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/core/rpdr_product_stage.sv]
// ----------------------------------------------------------------------------
// rpdr_product_stage
// Gain products. The integral product is split into two 32 by 24 halves.
// ----------------------------------------------------------------------------
module rpdr_product_stage import rpdr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  err_item_t  in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output prod_item_t out_item
);

  logic                            item_v_r;
  prod_item_t                      item_r;
  prod_item_t                      item_nxt;
  logic signed [SUM_W-HALF_W-1:0]  sum_hi;
  logic        [HALF_W-1:0]        sum_lo;

  assign in_ready  = !item_v_r || out_ready;
  assign out_valid = item_v_r;
  assign out_item  = item_r;

  // Four independent products; the gains are unsigned.
  always_comb begin
    sum_hi       = $signed(in_item.sum[SUM_W-1:HALF_W]);
    sum_lo       = in_item.sum[HALF_W-1:0];
    item_nxt.p   = P_W'($signed({1'b0, cfg.prop})) * P_W'(in_item.err);
    item_nxt.d   = D_W'($signed({1'b0, cfg.deriv})) * D_W'(in_item.diff);
    item_nxt.ilo = ILO_W'(cfg.integ) * ILO_W'(sum_lo);
    item_nxt.ihi = IHI_W'($signed({1'b0, cfg.integ})) * IHI_W'(sum_hi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
    end else if (in_ready) begin
      item_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= item_nxt;
    end
  end

endmodule

[rtl/core/rpdr_sum_stage.sv]
// ----------------------------------------------------------------------------
// rpdr_sum_stage
// Adds the partial products in two steps, floors the fixed-point sum to an
// integer and limits it to plus or minus two to the fortieth.
// ----------------------------------------------------------------------------
module rpdr_sum_stage import rpdr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  prod_item_t       in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PID_W-1:0] out_pid
);

  localparam logic signed [FL_W-1:0] FL_HI = FL_W'(1) <<< LIMIT_EXP;
  localparam logic signed [FL_W-1:0] FL_LO = -FL_HI;

  logic                    pair_v_r;
  pair_item_t              pair_r;
  pair_item_t              pair_nxt;
  logic                    pid_v_r;
  logic signed [PID_W-1:0] pid_r;
  logic signed [PID_W-1:0] pid_nxt;
  logic signed [ACC_W-1:0] p_x;
  logic signed [ACC_W-1:0] d_x;
  logic signed [ACC_W-1:0] lo_x;
  logic signed [ACC_W-1:0] hi_x;
  logic signed [ACC_W-1:0] acc;
  logic signed [FL_W-1:0]  fl;
  logic                    pid_rdy;

  assign pid_rdy   = !pid_v_r || out_ready;
  assign in_ready  = !pair_v_r || pid_rdy;
  assign out_valid = pid_v_r;
  assign out_pid   = pid_r;

  // First step: proportional plus derivative, and the two integral halves.
  always_comb begin
    p_x  = {{(ACC_W - P_W){in_item.p[P_W-1]}}, in_item.p};
    d_x  = {{(ACC_W - D_W){in_item.d[D_W-1]}}, in_item.d};
    lo_x = {{(ACC_W - ILO_W){1'b0}}, in_item.ilo};
    hi_x = {{(ACC_W - IHI_W - HALF_W){in_item.ihi[IHI_W-1]}}, in_item.ihi,
            {HALF_W{1'b0}}};
    pair_nxt.a = p_x + d_x;
    pair_nxt.b = lo_x + hi_x;
  end

  // Second step: total, floor by dropping the fraction, then limit.
  always_comb begin
    acc = pair_r.a + pair_r.b;
    fl  = $signed(acc[ACC_W-1:FRAC_W]);
    if (fl > FL_HI) begin
      pid_nxt = PID_W'(FL_HI);
    end else if (fl < FL_LO) begin
      pid_nxt = PID_W'(FL_LO);
    end else begin
      pid_nxt = fl[PID_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_v_r <= 1'b0;
      pid_v_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_v_r <= in_valid;
      end
      if (pid_rdy) begin
        pid_v_r <= pair_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pair_r <= pair_nxt;
    end
    if (pair_v_r && pid_rdy) begin
      pid_r <= pid_nxt;
    end
  end

endmodule

[rtl/core/rpdr_duty_stage.sv]
// ----------------------------------------------------------------------------
// rpdr_duty_stage
// Adds the correction to the held duty, clamps to the PWM range and holds
// the result word in the output register.
// ----------------------------------------------------------------------------
module rpdr_duty_stage import rpdr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [PID_W-1:0]  in_pid,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DUTY_W-1:0] out_duty,
  output logic              out_limited
);

  localparam logic signed [NEXT_W-1:0] NEXT_MAX = NEXT_W'(DUTY_MAX);

  logic                     out_v_r;
  logic [DUTY_W-1:0]        duty_level_r;
  logic [DUTY_W-1:0]        duty_nxt;
  logic [DUTY_W-1:0]        out_duty_r;
  logic                     out_lim_r;
  logic                     lim_nxt;
  logic signed [NEXT_W-1:0] pid_x;
  logic signed [NEXT_W-1:0] duty_x;
  logic signed [NEXT_W-1:0] next_val;
  logic                     take;

  assign in_ready    = !out_v_r || out_ready;
  assign take        = in_valid && in_ready;
  assign out_valid   = out_v_r;
  assign out_duty    = out_duty_r;
  assign out_limited = out_lim_r;

  // New duty; exactly zero or full scale is not a clamp.
  always_comb begin
    pid_x    = {{(NEXT_W - PID_W){in_pid[PID_W-1]}}, in_pid};
    duty_x   = {{(NEXT_W - DUTY_W){1'b0}}, duty_level_r};
    next_val = pid_x + duty_x;
    if (next_val[NEXT_W-1]) begin
      duty_nxt = '0;
      lim_nxt  = 1'b1;
    end else if (next_val > NEXT_MAX) begin
      duty_nxt = DUTY_W'(DUTY_MAX);
      lim_nxt  = 1'b1;
    end else begin
      duty_nxt = next_val[DUTY_W-1:0];
      lim_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r      <= 1'b0;
      duty_level_r <= '0;
    end else begin
      if (in_ready) begin
        out_v_r <= in_valid;
      end
      if (take) begin
        duty_level_r <= duty_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_duty_r <= duty_nxt;
      out_lim_r  <= lim_nxt;
    end
  end

endmodule

[rtl/core/rpdr_checker.sv]
// ----------------------------------------------------------------------------
// rpdr_checker
// Port-level checks of the speed regulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rpdr_checker import rpdr_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [15:0] in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tuser
);

  logic       in_stall;
  logic       out_stall;
  logic [8:0] out_word;
  logic       duty_at_end;

  // Stall conditions and the full result word.
  assign in_stall    = in_tvalid && !in_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign out_word    = {out_tuser, out_tdata};
  assign duty_at_end = (out_tdata == '0) || (out_tdata == DUTY_W'(DUTY_MAX));

  // Reset empties the pipeline and opens the input.
  `ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid && in_tready, "not empty after reset")

  // A stalled result word stays put.
  `ASSERT_CLK(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "held word changed")

  // A refused input word stays offered and unchanged.
  `ASSERT_CLK(a_in_hold, in_stall |=> in_tvalid && $stable(in_tdata), "input word changed")

  // The clamp flag only comes with a duty at either end of the range.
  `ASSERT_CLK(a_limit_ends, out_tvalid && out_tuser |-> duty_at_end, "clamp flag inside range")

  // The input only backs up when the whole pipeline is full behind a stall.
  `ASSERT_CLK(a_ready_full, !in_tready |-> out_stall, "input refused with room left")

endmodule

bind rpm_pid_duty_regulator rpdr_checker u_rpdr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
